[src/pn2d_pkg.sv]
// Shared widths, codes and fixed-point constants of the 2-D gradient noise block.
// No dependencies; imported by the channel interfaces and the top level.
`default_nettype none

package pn2d_pkg;

    // Field widths of the channels
    localparam int CMD_W   = 1;
    localparam int INDEX_W = 8;
    localparam int GRAD_W  = 16;
    localparam int COORD_W = 16;
    localparam int NOISE_W = 19;

    // Gradient table depth follows from the address width
    localparam int TABLE_DEPTH = 2 ** INDEX_W;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD = 1'b0,
        CMD_EVAL = 1'b1
    } cmd_t;

    // Internal datapath widths
    localparam int DELTA_W  = 18;   // signed offset a or a-1, Q2.16
    localparam int WEIGHT_W = 17;   // smoothstep weight, 0..65536
    localparam int CORNER_W = 34;   // corner dot product / row blend, signed Q2.32
    localparam int PROD_W   = 52;   // weighted term before rounding
    localparam int VAL_W    = 20;   // final value before clamp

    // Fixed-point constants
    localparam logic [WEIGHT_W-1:0] ONE_Q16   = 17'd65536;
    localparam logic [DELTA_W-1:0]  SMOOTH_K  = 18'd196608;  // 3.0 in Q2.16
    localparam logic signed [VAL_W-1:0] HALF_Q16 = 20'sd32768;
    localparam logic signed [VAL_W-1:0] OUT_MIN  = -20'sd98304;
    localparam logic signed [VAL_W-1:0] OUT_MAX  = 20'sd163840;

endpackage

`default_nettype wire

[src/pn2d_if.sv]
// Valid/ready channel interfaces of the 2-D gradient noise block.
// Depends on pn2d_pkg for field widths.
`default_nettype none

// Input items: table loads and noise evaluations
interface pn2d_item_if
    import pn2d_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [INDEX_W-1:0] entry_index;
    logic [GRAD_W-1:0]  grad_x;
    logic [GRAD_W-1:0]  grad_y;
    logic [COORD_W-1:0] coord_u;
    logic [COORD_W-1:0] coord_v;

    modport source (
        output valid, cmd, entry_index, grad_x, grad_y, coord_u, coord_v,
        input  ready
    );
    modport sink (
        input  valid, cmd, entry_index, grad_x, grad_y, coord_u, coord_v,
        output ready
    );
endinterface

// Result items: one noise sample per evaluation
interface pn2d_result_if
    import pn2d_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [NOISE_W-1:0] noise_value;

    modport source (
        output valid, noise_value,
        input  ready
    );
    modport sink (
        input  valid, noise_value,
        output ready
    );
endinterface

`default_nettype wire

[src/perlin_noise_2d.sv]
// Top level of the 2-D gradient noise block: gradient tables and the full pipeline.
// Depends on pn2d_pkg and the channel interfaces in pn2d_if.sv.
//
// Usage:
//   item   - input channel. cmd = CMD_LOAD writes grad_x/grad_y into table entry
//            entry_index; cmd = CMD_EVAL evaluates noise at (coord_u, coord_v).
//   result - one noise_value (signed Q3.16, noise + 0.5) per evaluate transfer,
//            in order; loads produce no result.
//   Throughput: one item per cycle while the receiver does not stall. Eight register
//   stages: each item passes stages 1 to 7 and then the stage 8 output register.
//   The table is replicated in two 256 x 32 memories, each read at two
//   addresses per cycle, so all four corners are fetched in one stage.
//   Loads write the table in the same stage where evaluations read it, so
//   every evaluation sees exactly the loads that preceded it.
//   Stall: the whole pipeline holds while a result waits untaken; item.ready
//   drops only then. Nothing is lost or repeated.
//   Reset: clears all valid bits; table contents stay undefined until loaded.
//   GRID_SIZE (2..256) sets the grid; addresses wrap modulo 256.
`default_nettype none

module perlin_noise_2d
    import pn2d_pkg::*;
#(
    parameter int GRID_SIZE = 16
)(
    input  logic           clk,
    input  logic           rst_n,
    pn2d_item_if.sink      item,
    pn2d_result_if.source  result
);

    localparam int CELL_W = $clog2(GRID_SIZE);
    localparam int XS_W   = COORD_W + CELL_W;
    localparam logic [CELL_W-1:0]  GRID_M1  = CELL_W'(GRID_SIZE - 1);
    localparam logic [INDEX_W-1:0] GRID_MOD = INDEX_W'(GRID_SIZE % TABLE_DEPTH);
    localparam int ENTRY_W = 2 * GRAD_W;

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    // gx*dx + gy*dy, exact in signed Q2.32
    function automatic logic signed [CORNER_W-1:0] corner_dot(
        input logic [GRAD_W-1:0]         gx,
        input logic [GRAD_W-1:0]         gy,
        input logic signed [DELTA_W-1:0] dx,
        input logic signed [DELTA_W-1:0] dy
    );
        logic signed [CORNER_W-1:0] gxs;
        logic signed [CORNER_W-1:0] gys;
        logic signed [CORNER_W-1:0] dxs;
        logic signed [CORNER_W-1:0] dys;
        gxs = {{(CORNER_W-GRAD_W){1'b0}}, gx};
        gys = {{(CORNER_W-GRAD_W){1'b0}}, gy};
        dxs = {{(CORNER_W-DELTA_W){dx[DELTA_W-1]}}, dx};
        dys = {{(CORNER_W-DELTA_W){dy[DELTA_W-1]}}, dy};
        return gxs * dxs + gys * dys;
    endfunction

    // signed Q2.32 value times unsigned weight
    function automatic logic signed [PROD_W-1:0] weigh(
        input logic signed [CORNER_W-1:0] c,
        input logic [WEIGHT_W-1:0]        w
    );
        logic signed [PROD_W-1:0] cs;
        logic signed [PROD_W-1:0] ws;
        cs = {{(PROD_W-CORNER_W){c[CORNER_W-1]}}, c};
        ws = {{(PROD_W-WEIGHT_W){1'b0}}, w};
        return cs * ws;
    endfunction

    // ------------------------------------------------------------------
    // Pipeline registers
    // ------------------------------------------------------------------
    logic en;

    // stage 1: captured input
    logic v1_reg, v1_next;
    logic [CMD_W-1:0]   cmd1_reg, cmd1_next;
    logic [INDEX_W-1:0] idx1_reg, idx1_next;
    logic [GRAD_W-1:0]  gx1_reg, gx1_next, gy1_reg, gy1_next;
    logic [COORD_W-1:0] cu1_reg, cu1_next, cv1_reg, cv1_next;

    // stage 2: cell and fraction
    logic v2_reg, v2_next;
    logic [CMD_W-1:0]   cmd2_reg, cmd2_next;
    logic [INDEX_W-1:0] idx2_reg, idx2_next;
    logic [GRAD_W-1:0]  gx2_reg, gx2_next, gy2_reg, gy2_next;
    logic [CELL_W-1:0]  ci2_reg, ci2_next, cj2_reg, cj2_next;
    logic [COORD_W-1:0] a2_reg, a2_next, b2_reg, b2_next;

    // stage 3: table read, squares for the weights
    logic v3_reg, v3_next;
    logic [CMD_W-1:0]   cmd3_reg, cmd3_next;
    logic [COORD_W-1:0] a3_reg, a3_next, b3_reg, b3_next;
    logic [2*COORD_W-1:0] aa3_reg, aa3_next, bb3_reg, bb3_next;
    logic [DELTA_W-1:0] ta3_reg, ta3_next, tb3_reg, tb3_next;
    logic [ENTRY_W-1:0] rd00_reg, rd10_reg, rd01_reg, rd11_reg;

    // stage 4: corners and weights
    logic v4_reg, v4_next;
    logic signed [CORNER_W-1:0] c00_4_reg, c00_4_next, c10_4_reg, c10_4_next;
    logic signed [CORNER_W-1:0] c01_4_reg, c01_4_next, c11_4_reg, c11_4_next;
    logic [WEIGHT_W-1:0] wi4_reg, wi4_next, wj4_reg, wj4_next;

    // stage 5: horizontal weighted terms
    logic v5_reg, v5_next;
    logic signed [PROD_W-1:0] p00_5_reg, p00_5_next, p10_5_reg, p10_5_next;
    logic signed [PROD_W-1:0] p01_5_reg, p01_5_next, p11_5_reg, p11_5_next;
    logic [WEIGHT_W-1:0] wj5_reg, wj5_next;

    // stage 6: row blends
    logic v6_reg, v6_next;
    logic signed [CORNER_W-1:0] h0_6_reg, h0_6_next, h1_6_reg, h1_6_next;
    logic [WEIGHT_W-1:0] wj6_reg, wj6_next;

    // stage 7: vertical weighted terms
    logic v7_reg, v7_next;
    logic signed [PROD_W-1:0] q0_7_reg, q0_7_next, q1_7_reg, q1_7_next;

    // stage 8: output register
    logic out_valid_reg, out_valid_next;
    logic signed [NOISE_W-1:0] noise_reg, noise_next;

    // combinational intermediates
    logic [XS_W-1:0]    xs, ys;
    logic [INDEX_W-1:0] col0, col1, row0, row1;
    logic [INDEX_W-1:0] addr00, addr10, addr01, addr11;
    logic               tab_wr;
    logic signed [DELTA_W-1:0] dx0, dx1, dy0, dy1;
    logic [2*COORD_W+DELTA_W-1:0] pa, pb;
    logic signed [PROD_W-1:0] hs0, hs1, vs;
    logic signed [VAL_W-1:0]  val;

    // gradient tables, {grad_x, grad_y}; two copies give four read ports
    logic [ENTRY_W-1:0] tab_a_mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] tab_b_mem [TABLE_DEPTH];

    // pipeline advances unless a result waits untaken
    assign en          = !out_valid_reg || result.ready;
    assign item.ready  = en;
    assign result.valid       = out_valid_reg;
    assign result.noise_value = noise_reg;

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb
    begin
        // stage 1: capture transfer
        v1_next   = item.valid;
        cmd1_next = item.cmd;
        idx1_next = item.entry_index;
        gx1_next  = item.grad_x;
        gy1_next  = item.grad_y;
        cu1_next  = item.coord_u;
        cv1_next  = item.coord_v;

        // stage 2: scale by GRID_SIZE-1, split cell and fraction
        xs        = XS_W'(GRID_M1) * XS_W'(cu1_reg);
        ys        = XS_W'(GRID_M1) * XS_W'(cv1_reg);
        v2_next   = v1_reg;
        cmd2_next = cmd1_reg;
        idx2_next = idx1_reg;
        gx2_next  = gx1_reg;
        gy2_next  = gy1_reg;
        ci2_next  = xs[XS_W-1:COORD_W];
        cj2_next  = ys[XS_W-1:COORD_W];
        a2_next   = xs[COORD_W-1:0];
        b2_next   = ys[COORD_W-1:0];

        // stage 3: corner addresses, modulo table depth
        col0   = INDEX_W'(ci2_reg);
        col1   = col0 + INDEX_W'(1);
        row0   = INDEX_W'(cj2_reg) * GRID_MOD;
        row1   = row0 + GRID_MOD;
        addr00 = col0 + row0;
        addr10 = col1 + row0;
        addr01 = col0 + row1;
        addr11 = col1 + row1;
        tab_wr = en && v2_reg && (cmd2_reg == CMD_LOAD);

        v3_next   = v2_reg;
        cmd3_next = cmd2_reg;
        a3_next   = a2_reg;
        b3_next   = b2_reg;
        aa3_next  = {{COORD_W{1'b0}}, a2_reg} * {{COORD_W{1'b0}}, a2_reg};
        bb3_next  = {{COORD_W{1'b0}}, b2_reg} * {{COORD_W{1'b0}}, b2_reg};
        ta3_next  = SMOOTH_K - {1'b0, a2_reg, 1'b0};
        tb3_next  = SMOOTH_K - {1'b0, b2_reg, 1'b0};

        // stage 4: corner dot products, smoothstep weights
        dx0 = {2'b00, a3_reg};
        dx1 = {2'b11, a3_reg};
        dy0 = {2'b00, b3_reg};
        dy1 = {2'b11, b3_reg};
        v4_next    = v3_reg && (cmd3_reg == CMD_EVAL);
        c00_4_next = corner_dot(rd00_reg[ENTRY_W-1:GRAD_W], rd00_reg[GRAD_W-1:0], dx0, dy0);
        c10_4_next = corner_dot(rd10_reg[ENTRY_W-1:GRAD_W], rd10_reg[GRAD_W-1:0], dx1, dy0);
        c01_4_next = corner_dot(rd01_reg[ENTRY_W-1:GRAD_W], rd01_reg[GRAD_W-1:0], dx0, dy1);
        c11_4_next = corner_dot(rd11_reg[ENTRY_W-1:GRAD_W], rd11_reg[GRAD_W-1:0], dx1, dy1);
        pa = {{DELTA_W{1'b0}}, aa3_reg} * {{(2*COORD_W){1'b0}}, ta3_reg};
        pb = {{DELTA_W{1'b0}}, bb3_reg} * {{(2*COORD_W){1'b0}}, tb3_reg};
        pa = pa + ((2*COORD_W+DELTA_W)'(1) << 31);
        pb = pb + ((2*COORD_W+DELTA_W)'(1) << 31);
        wi4_next = pa[32 +: WEIGHT_W];
        wj4_next = pb[32 +: WEIGHT_W];

        // stage 5: horizontal weighted terms
        v5_next    = v4_reg;
        p00_5_next = weigh(c00_4_reg, ONE_Q16 - wi4_reg);
        p10_5_next = weigh(c10_4_reg, wi4_reg);
        p01_5_next = weigh(c01_4_reg, ONE_Q16 - wi4_reg);
        p11_5_next = weigh(c11_4_reg, wi4_reg);
        wj5_next   = wj4_reg;

        // stage 6: row sums, round half up to Q2.32
        hs0 = p00_5_reg + p10_5_reg + (PROD_W'(1) << 15);
        hs1 = p01_5_reg + p11_5_reg + (PROD_W'(1) << 15);
        v6_next   = v5_reg;
        h0_6_next = hs0[16 +: CORNER_W];
        h1_6_next = hs1[16 +: CORNER_W];
        wj6_next  = wj5_reg;

        // stage 7: vertical weighted terms
        v7_next   = v6_reg;
        q0_7_next = weigh(h0_6_reg, ONE_Q16 - wj6_reg);
        q1_7_next = weigh(h1_6_reg, wj6_reg);

        // stage 8: round to Q2.16, add 0.5, clamp
        vs  = q0_7_reg + q1_7_reg + (PROD_W'(1) << 31);
        val = vs[32 +: VAL_W] + HALF_Q16;
        if (val < OUT_MIN)
        begin
            val = OUT_MIN;
        end
        if (val > OUT_MAX)
        begin
            val = OUT_MAX;
        end
        out_valid_next = v7_reg;
        noise_next     = val[NOISE_W-1:0];
    end

    // ------------------------------------------------------------------
    // Valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            v3_reg        <= v3_next;
            v4_reg        <= v4_next;
            v5_reg        <= v5_next;
            v6_reg        <= v6_next;
            v7_reg        <= v7_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd1_reg  <= cmd1_next;
            idx1_reg  <= idx1_next;
            gx1_reg   <= gx1_next;
            gy1_reg   <= gy1_next;
            cu1_reg   <= cu1_next;
            cv1_reg   <= cv1_next;

            cmd2_reg  <= cmd2_next;
            idx2_reg  <= idx2_next;
            gx2_reg   <= gx2_next;
            gy2_reg   <= gy2_next;
            ci2_reg   <= ci2_next;
            cj2_reg   <= cj2_next;
            a2_reg    <= a2_next;
            b2_reg    <= b2_next;

            cmd3_reg  <= cmd3_next;
            a3_reg    <= a3_next;
            b3_reg    <= b3_next;
            aa3_reg   <= aa3_next;
            bb3_reg   <= bb3_next;
            ta3_reg   <= ta3_next;
            tb3_reg   <= tb3_next;

            c00_4_reg <= c00_4_next;
            c10_4_reg <= c10_4_next;
            c01_4_reg <= c01_4_next;
            c11_4_reg <= c11_4_next;
            wi4_reg   <= wi4_next;
            wj4_reg   <= wj4_next;

            p00_5_reg <= p00_5_next;
            p10_5_reg <= p10_5_next;
            p01_5_reg <= p01_5_next;
            p11_5_reg <= p11_5_next;
            wj5_reg   <= wj5_next;

            h0_6_reg  <= h0_6_next;
            h1_6_reg  <= h1_6_next;
            wj6_reg   <= wj6_next;

            q0_7_reg  <= q0_7_next;
            q1_7_reg  <= q1_7_next;

            noise_reg <= noise_next;
        end
    end

    // ------------------------------------------------------------------
    // Gradient tables: write on load, registered reads for evaluations
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (tab_wr)
        begin
            tab_a_mem[idx2_reg] <= {gx2_reg, gy2_reg};
            tab_b_mem[idx2_reg] <= {gx2_reg, gy2_reg};
        end
        if (en)
        begin
            rd00_reg <= tab_a_mem[addr00];
            rd10_reg <= tab_a_mem[addr10];
            rd01_reg <= tab_b_mem[addr01];
            rd11_reg <= tab_b_mem[addr11];
        end
    end

`ifndef SYNTHESIS
    // input is held back only while a result waits at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> result.valid)
    else $error("item.ready low without a pending result");

    // a new result comes from a valid item in the last stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(v7_reg))
    else $error("result raised without an item in the last stage");

    // only evaluations pass beyond the table stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && $past(item.ready)) |-> $past(v3_reg && (cmd3_reg == CMD_EVAL)))
    else $error("load item passed beyond the table stage");
`endif

endmodule

`default_nettype wire
